// ===== rtl/sngt_pkg.sv =====
// Shared types and constants for the sorted neighbor gain table.
// Holds widths, word formats, entry layout, sequencer states and register codes.
// No dependencies.
package sngt_pkg;

    localparam int TABLE_DEPTH = 16;
    localparam int IDX_W       = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);

    localparam int ADDR_W      = 16;
    localparam int ED_W        = 8;
    localparam int WEIGHT_W    = 9;
    localparam int TYPE_W      = 2;
    localparam int COUNT_W     = 5;
    localparam int CFG_IDX_W   = 1;
    localparam int CFG_DATA_W  = 9;

    // request codes; the unused code acts as a lookup
    localparam logic [TYPE_W-1:0] REQ_INBOUND  = 2'd0;
    localparam logic [TYPE_W-1:0] REQ_OUTBOUND = 2'd1;
    localparam logic [TYPE_W-1:0] REQ_LOOKUP   = 2'd2;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_SMOOTHING_WEIGHT = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_INVALID_READING  = 1'd1;

    localparam logic [WEIGHT_W-1:0]   WEIGHT_RESET  = 9'd64;
    localparam logic signed [ED_W-1:0] INVALID_RESET = 8'sd127;
    localparam logic [WEIGHT_W-1:0]   WEIGHT_MAX    = 9'd256;

    typedef struct packed {
        logic [TYPE_W-1:0]      req_type;
        logic [ADDR_W-1:0]      neighbor_addr;
        logic signed [ED_W-1:0] ed_value;
    } req_t;

    typedef struct packed {
        logic                   found;
        logic                   status;
        logic signed [ED_W-1:0] inbound_reading;
        logic signed [ED_W-1:0] outbound_reading;
        logic [COUNT_W-1:0]     entry_count;
    } rsp_t;

    typedef struct packed {
        logic [ADDR_W-1:0]      addr;
        logic signed [ED_W-1:0] inb;
        logic signed [ED_W-1:0] outb;
    } entry_t;

    typedef struct packed {
        logic             wr_en;
        logic [IDX_W-1:0] wr_idx;
        entry_t           wr_entry;
        logic [IDX_W-1:0] rd_idx;
    } tbl_ctl_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SEARCH,
        ST_DECIDE,
        ST_MUL,
        ST_DIV,
        ST_UP,
        ST_DOWN,
        ST_DONE
    } sngt_state_t;

endpackage

// ===== rtl/sngt_table.sv =====
// Neighbor entry storage: one write and one read per cycle.
// Depends on sngt_pkg.
module sngt_table
    import sngt_pkg::*;
(
    input  logic     clk,
    input  tbl_ctl_t ctl,
    output entry_t   rd_entry
);

    entry_t entry_reg [TABLE_DEPTH];

    always_ff @(posedge clk)
    begin
        if (ctl.wr_en)
        begin
            entry_reg[ctl.wr_idx] <= ctl.wr_entry;
        end
    end

    assign rd_entry = entry_reg[ctl.rd_idx];

endmodule

// ===== rtl/sngt_smooth.sv =====
// Inbound reading smoother: old + (new - old) * w / 256, truncated toward zero.
// One registered multiply, result valid the cycle after start. Depends on sngt_pkg.
module sngt_smooth
    import sngt_pkg::*;
(
    input  logic                   clk,
    input  logic                   start,
    input  logic [WEIGHT_W-1:0]    weight,
    input  logic signed [ED_W-1:0] old_val,
    input  logic signed [ED_W-1:0] new_val,
    output logic signed [ED_W-1:0] result
);

    logic [WEIGHT_W-1:0]    w_clamped;
    logic signed [ED_W:0]   diff;
    logic signed [18:0]     prod_next;
    logic signed [18:0]     prod_reg;
    logic signed [ED_W-1:0] old_reg;
    logic signed [18:0]     sum;
    logic [18:0]            mag;
    logic [7:0]             quot;

    always_comb
    begin
        w_clamped = (weight > WEIGHT_MAX) ? WEIGHT_MAX : weight;
        diff      = 9'(new_val) - 9'(old_val);
        prod_next = 19'(diff) * 19'($signed({1'b0, w_clamped}));
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            prod_reg <= prod_next;
            old_reg  <= old_val;
        end
    end

    always_comb
    begin
        sum  = {{3{old_reg[ED_W-1]}}, old_reg, 8'd0} + prod_reg;
        mag  = sum[18] ? 19'(-sum) : 19'(sum);
        quot = mag[15:8];   // magnitude never exceeds 128
        result = sum[18] ? $signed(8'(8'd0 - quot)) : $signed(quot);
    end

endmodule

// ===== rtl/sngt_ctrl.sv =====
// Request sequencer: linear search, update, insertion move and result register.
// Drives sngt_table and sngt_smooth. Depends on sngt_pkg.
module sngt_ctrl
    import sngt_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   req_valid,
    output logic                   req_ready,
    input  req_t                   req,
    output logic                   rsp_valid,
    input  logic                   rsp_ready,
    output rsp_t                   rsp,
    input  logic signed [ED_W-1:0] invalid_reading,
    output tbl_ctl_t               tbl_ctl,
    input  entry_t                 tbl_rd,
    output logic                   mul_start,
    output logic signed [ED_W-1:0] mul_old,
    output logic signed [ED_W-1:0] mul_new,
    input  logic signed [ED_W-1:0] mul_result
);

    sngt_state_t            state_reg, state_next;
    req_t                   cur_req_reg, cur_req_next;
    logic [CNT_W-1:0]       idx_reg, idx_next;
    logic [CNT_W-1:0]       count_reg, count_next;
    logic                   found_reg, found_next;
    logic                   status_reg, status_next;
    logic                   moved_reg, moved_next;
    logic signed [ED_W-1:0] cur_in_reg, cur_in_next;
    logic signed [ED_W-1:0] cur_ob_reg, cur_ob_next;
    logic                   rsp_valid_reg, rsp_valid_next;
    rsp_t                   rsp_reg, rsp_next;

    logic [CNT_W-1:0]       idx_dec;
    logic [CNT_W-1:0]       idx_inc;
    logic                   has_room;
    entry_t                 own_entry;

    assign idx_dec   = idx_reg - 1'b1;
    assign idx_inc   = idx_reg + 1'b1;
    assign has_room  = count_reg < CNT_W'(TABLE_DEPTH);
    assign req_ready = (state_reg == ST_IDLE);
    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;
    assign mul_old   = cur_in_reg;
    assign mul_new   = cur_req_reg.ed_value;

    always_comb
    begin
        own_entry.addr = cur_req_reg.neighbor_addr;
        own_entry.inb  = cur_in_reg;
        own_entry.outb = cur_ob_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            count_reg     <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cur_req_reg <= cur_req_next;
        idx_reg     <= idx_next;
        found_reg   <= found_next;
        status_reg  <= status_next;
        moved_reg   <= moved_next;
        cur_in_reg  <= cur_in_next;
        cur_ob_reg  <= cur_ob_next;
        rsp_reg     <= rsp_next;
    end

    always_comb
    begin
        state_next     = state_reg;
        cur_req_next   = cur_req_reg;
        idx_next       = idx_reg;
        count_next     = count_reg;
        found_next     = found_reg;
        status_next    = status_reg;
        moved_next     = moved_reg;
        cur_in_next    = cur_in_reg;
        cur_ob_next    = cur_ob_reg;
        rsp_valid_next = rsp_valid_reg && !rsp_ready;
        rsp_next       = rsp_reg;
        mul_start      = 1'b0;
        tbl_ctl.wr_en    = 1'b0;
        tbl_ctl.wr_idx   = idx_reg[IDX_W-1:0];
        tbl_ctl.wr_entry = own_entry;
        tbl_ctl.rd_idx   = idx_reg[IDX_W-1:0];

        case (state_reg)
            ST_IDLE:
            begin
                if (req_valid)
                begin
                    cur_req_next = req;
                    idx_next     = '0;
                    found_next   = 1'b0;
                    status_next  = 1'b0;
                    state_next   = ST_SEARCH;
                end
            end

            ST_SEARCH:
            begin
                if (idx_reg == count_reg)
                begin
                    state_next = ST_DECIDE;
                end
                else if (tbl_rd.addr == cur_req_reg.neighbor_addr)
                begin
                    found_next  = 1'b1;
                    cur_in_next = tbl_rd.inb;
                    cur_ob_next = tbl_rd.outb;
                    state_next  = ST_DECIDE;
                end
                else
                begin
                    idx_next = idx_inc;
                end
            end

            ST_DECIDE:
            begin
                moved_next = 1'b0;
                state_next = ST_DONE;
                case (cur_req_reg.req_type)
                    REQ_INBOUND:
                    begin
                        if (found_reg)
                        begin
                            if (cur_in_reg != invalid_reading)
                            begin
                                state_next = ST_MUL;
                            end
                            else
                            begin
                                cur_in_next = cur_req_reg.ed_value;
                                state_next  = ST_UP;
                            end
                        end
                        else if (has_room)
                        begin
                            idx_next    = count_reg;
                            count_next  = count_reg + 1'b1;
                            cur_in_next = cur_req_reg.ed_value;
                            cur_ob_next = invalid_reading;
                            state_next  = ST_UP;
                        end
                        else
                        begin
                            status_next = 1'b1;
                            cur_in_next = invalid_reading;
                            cur_ob_next = invalid_reading;
                        end
                    end

                    REQ_OUTBOUND:
                    begin
                        if (found_reg || has_room)
                        begin
                            tbl_ctl.wr_en         = 1'b1;
                            tbl_ctl.wr_entry.outb = cur_req_reg.ed_value;
                            cur_ob_next           = cur_req_reg.ed_value;
                            if (!found_reg)
                            begin
                                tbl_ctl.wr_idx       = count_reg[IDX_W-1:0];
                                tbl_ctl.wr_entry.inb = invalid_reading;
                                cur_in_next          = invalid_reading;
                                count_next           = count_reg + 1'b1;
                            end
                        end
                        else
                        begin
                            status_next = 1'b1;
                            cur_in_next = invalid_reading;
                            cur_ob_next = invalid_reading;
                        end
                    end

                    default:
                    begin
                        if (!found_reg)
                        begin
                            cur_in_next = invalid_reading;
                            cur_ob_next = invalid_reading;
                        end
                    end
                endcase
            end

            ST_MUL:
            begin
                mul_start  = 1'b1;
                state_next = ST_DIV;
            end

            ST_DIV:
            begin
                cur_in_next = mul_result;
                state_next  = ST_UP;
            end

            ST_UP:
            begin
                tbl_ctl.rd_idx = idx_dec[IDX_W-1:0];
                if (idx_reg != '0 && cur_in_reg > tbl_rd.inb)
                begin
                    tbl_ctl.wr_en    = 1'b1;
                    tbl_ctl.wr_entry = tbl_rd;
                    idx_next         = idx_dec;
                    moved_next       = 1'b1;
                end
                else if (moved_reg)
                begin
                    tbl_ctl.wr_en = 1'b1;
                    state_next    = ST_DONE;
                end
                else
                begin
                    state_next = ST_DOWN;
                end
            end

            ST_DOWN:
            begin
                tbl_ctl.rd_idx = idx_inc[IDX_W-1:0];
                tbl_ctl.wr_en  = 1'b1;
                if (idx_inc < count_reg && cur_in_reg < tbl_rd.inb)
                begin
                    tbl_ctl.wr_entry = tbl_rd;
                    idx_next         = idx_inc;
                end
                else
                begin
                    state_next = ST_DONE;
                end
            end

            ST_DONE:
            begin
                if (!rsp_valid_reg || rsp_ready)
                begin
                    rsp_valid_next            = 1'b1;
                    rsp_next.found            = found_reg;
                    rsp_next.status           = status_reg;
                    rsp_next.inbound_reading  = cur_in_reg;
                    rsp_next.outbound_reading = cur_ob_reg;
                    rsp_next.entry_count      = COUNT_W'(count_reg);
                    state_next                = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // entry count never passes the table size
    assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(TABLE_DEPTH))
        else $error("entry count above table depth");

    // the table only grows, one entry per request
    assert property (@(posedge clk) disable iff (!rst_n)
        count_reg != $past(count_reg) |-> count_reg == $past(count_reg) + 1'b1)
        else $error("entry count moved by other than one");

    // a dropped insert only happens on a full table and never for a known neighbor
    assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid_reg && rsp_reg.status |->
            !rsp_reg.found && rsp_reg.entry_count == COUNT_W'(TABLE_DEPTH))
        else $error("full status on a table with room or a found neighbor");

    // a dropped insert reports no readings
    assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid_reg && rsp_reg.status |->
            rsp_reg.inbound_reading == invalid_reading &&
            rsp_reg.outbound_reading == invalid_reading)
        else $error("dropped insert reported a reading");

    // a finished word must not be overwritten while it waits
    assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_DONE && rsp_valid_reg && !rsp_ready |=> state_reg == ST_DONE)
        else $error("result word overwritten under stall");

endmodule

// ===== rtl/sorted_neighbor_gain_table.sv =====
// Top level of the sorted neighbor gain table.
// Holds the configuration registers and ties sngt_ctrl, sngt_table and sngt_smooth.
// Depends on sngt_pkg.
//
// Usage:
//   req channel (req_valid/req_ready/req) takes one request word: type, neighbor
//   address and energy reading. rsp channel (rsp_valid/rsp_ready/rsp) returns one
//   result word per request. cfg_we/cfg_index/cfg_wdata write the smoothing weight
//   (index 0) and the invalid-reading sentinel (index 1); write
//   them only while no request is in flight.
//   One request is worked at a time. A linear search reads the valid entries one
//   by one through the table's single read port, then a decide step picks the
//   action; when a known reading is blended the smoothing multiply runs in the
//   MUL and DIV states. For inbound requests the insertion reorder then shifts
//   neighbors one position per step, first upward and else downward, until the
//   entry's place is found, and writes the entry there.
//   The result sits in an output register; the next request is taken while it
//   waits, but a second result holds in the sequencer until the receiver drains
//   the first. Reset empties the table (count to zero) and restores weight 64
//   and sentinel 127; no clearing pass is needed.
module sorted_neighbor_gain_table
    import sngt_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  req_valid,
    output logic                  req_ready,
    input  req_t                  req,
    output logic                  rsp_valid,
    input  logic                  rsp_ready,
    output rsp_t                  rsp,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_wdata
);

    logic [WEIGHT_W-1:0]    weight_reg;
    logic signed [ED_W-1:0] invalid_reg;

    tbl_ctl_t               tbl_ctl;
    entry_t                 tbl_rd;
    logic                   mul_start;
    logic signed [ED_W-1:0] mul_old;
    logic signed [ED_W-1:0] mul_new;
    logic signed [ED_W-1:0] mul_result;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            weight_reg  <= WEIGHT_RESET;
            invalid_reg <= INVALID_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_SMOOTHING_WEIGHT: weight_reg  <= cfg_wdata[WEIGHT_W-1:0];
                CFG_INVALID_READING:  invalid_reg <= $signed(cfg_wdata[ED_W-1:0]);
                default:              weight_reg  <= weight_reg;
            endcase
        end
    end

    sngt_ctrl u_ctrl (
        .clk             (clk),
        .rst_n           (rst_n),
        .req_valid       (req_valid),
        .req_ready       (req_ready),
        .req             (req),
        .rsp_valid       (rsp_valid),
        .rsp_ready       (rsp_ready),
        .rsp             (rsp),
        .invalid_reading (invalid_reg),
        .tbl_ctl         (tbl_ctl),
        .tbl_rd          (tbl_rd),
        .mul_start       (mul_start),
        .mul_old         (mul_old),
        .mul_new         (mul_new),
        .mul_result      (mul_result)
    );

    sngt_table u_table (
        .clk      (clk),
        .ctl      (tbl_ctl),
        .rd_entry (tbl_rd)
    );

    sngt_smooth u_smooth (
        .clk     (clk),
        .start   (mul_start),
        .weight  (weight_reg),
        .old_val (mul_old),
        .new_val (mul_new),
        .result  (mul_result)
    );

endmodule
